>>> rtl/core/nulk_pkg.sv
// Shared types and constants for the nearest unique label keeper.
// Depends on nothing; every other file of the block imports this package.
package nulk_pkg;

    localparam int KEY_W          = 16;
    localparam int COORD_W        = 24;
    localparam int MAG_W          = COORD_W + 1;
    localparam int DIST_W         = 2 * MAG_W;
    localparam int CFG_INDEX_W    = 2;
    localparam int KEEP_COUNT_DEF = 5;
    localparam int QUEUE_DEPTH    = 2;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_CENTER_X = 2'd0,
        CFG_CENTER_Y = 2'd1
    } cfg_reg_t;

    typedef struct packed {
        logic [KEY_W-1:0]          label_key;
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic                      first_of_set;
        logic                      last_of_set;
    } in_item_t;

    typedef struct packed {
        logic [KEY_W-1:0]          kept_key;
        logic signed [COORD_W-1:0] kept_x;
        logic signed [COORD_W-1:0] kept_y;
        logic                      final_entry;
    } out_item_t;

    // One classified item on its way from the front end to the table.
    typedef struct packed {
        logic [KEY_W-1:0]          label_key;
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic                      first_of_set;
        logic                      last_of_set;
        logic [DIST_W-1:0]         sq_dist;
    } job_t;

endpackage

>>> rtl/core/nulk_front.sv
// Front end: holds the center registers and computes the squared distance
// of each accepted item in a two-stage pipeline. Depends on nulk_pkg.
module nulk_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    input  logic [nulk_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic signed [nulk_pkg::COORD_W-1:0] cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  nulk_pkg::in_item_t                in_item,
    output logic                              push,
    input  logic                              queue_full,
    output nulk_pkg::job_t                    push_job
);
    import nulk_pkg::*;

    logic signed [COORD_W-1:0] center_x_reg, center_x_next;
    logic signed [COORD_W-1:0] center_y_reg, center_y_next;
    logic                      s1_valid_reg, s1_valid_next;
    logic                      s2_valid_reg, s2_valid_next;
    in_item_t                  s1_item_reg;
    in_item_t                  s2_item_reg;
    logic [MAG_W-1:0]          s1_mag_x_reg, s1_mag_y_reg;
    logic [DIST_W-1:0]         s2_sq_x_reg, s2_sq_y_reg;
    logic                      adv1, adv2, in_take;

    // Magnitude of a 25-bit difference; the most negative case reads as 2^24.
    function automatic logic [MAG_W-1:0] abs_diff(
        input logic signed [COORD_W-1:0] p,
        input logic signed [COORD_W-1:0] c
    );
        logic [MAG_W-1:0] d;
        begin
            d = {p[COORD_W-1], p} - {c[COORD_W-1], c};
            abs_diff = d[MAG_W-1] ? (~d + 1'b1) : d;
        end
    endfunction

    assign adv2     = !s2_valid_reg || !queue_full;
    assign adv1     = !s1_valid_reg || adv2;
    assign in_stall = !adv1;
    assign in_take  = in_valid && adv1;
    assign push     = s2_valid_reg && !queue_full;

    always_comb
    begin
        push_job.label_key    = s2_item_reg.label_key;
        push_job.point_x      = s2_item_reg.point_x;
        push_job.point_y      = s2_item_reg.point_y;
        push_job.first_of_set = s2_item_reg.first_of_set;
        push_job.last_of_set  = s2_item_reg.last_of_set;
        push_job.sq_dist      = s2_sq_x_reg + s2_sq_y_reg;
    end

    always_comb
    begin
        center_x_next = center_x_reg;
        center_y_next = center_y_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_CENTER_X: center_x_next = cfg_data;
                CFG_CENTER_Y: center_y_next = cfg_data;
                default:      center_x_next = center_x_reg;
            endcase
        end
        s1_valid_next = adv1 ? in_valid : s1_valid_reg;
        s2_valid_next = adv2 ? s1_valid_reg : s2_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg <= '0;
            center_y_reg <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            center_x_reg <= center_x_next;
            center_y_reg <= center_y_next;
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_item_reg  <= in_item;
            s1_mag_x_reg <= abs_diff(in_item.point_x, center_x_reg);
            s1_mag_y_reg <= abs_diff(in_item.point_y, center_y_reg);
        end
        if (adv2 && s1_valid_reg)
        begin
            s2_item_reg <= s1_item_reg;
            s2_sq_x_reg <= s1_mag_x_reg * s1_mag_x_reg;
            s2_sq_y_reg <= s1_mag_y_reg * s1_mag_y_reg;
        end
    end

endmodule

>>> rtl/core/nulk_queue.sv
// Short first-in first-out queue of classified items between the front end
// and the table engine. Depends on nulk_pkg.
module nulk_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  nulk_pkg::job_t push_job,
    output logic           full,
    input  logic           pop,
    output logic           empty,
    output nulk_pkg::job_t head
);
    import nulk_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    job_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        begin
            bump = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
        end
    endfunction

    assign full    = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign head    = entry_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = do_push ? bump(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = do_pop ? bump(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

>>> rtl/core/nulk_back.sv
// Table engine: looks up, inserts or replaces entries, recomputes the
// farthest slot and emits the table through an output register. Depends on nulk_pkg.
module nulk_back #(
    parameter int KEEP_COUNT = nulk_pkg::KEEP_COUNT_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                head_valid,
    input  nulk_pkg::job_t      head,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_stall,
    output nulk_pkg::out_item_t out_item
);
    import nulk_pkg::*;

    localparam int SLOT_W = (KEEP_COUNT > 1) ? $clog2(KEEP_COUNT) : 1;
    localparam int CNT_W  = $clog2(KEEP_COUNT + 1);

    typedef enum logic [2:0] {
        ST_LOOKUP   = 3'b001,
        ST_FARTHEST = 3'b010,
        ST_EMIT     = 3'b100
    } back_state_t;

    back_state_t               state_reg, state_next;
    logic [CNT_W-1:0]          used_reg, used_next;
    logic [SLOT_W-1:0]         farthest_reg, farthest_next;
    logic                      last_reg, last_next;
    logic [SLOT_W-1:0]         emit_idx_reg, emit_idx_next;
    logic                      out_valid_reg, out_valid_next;
    out_item_t                 out_item_reg;

    logic [KEY_W-1:0]          slot_key_reg  [KEEP_COUNT];
    logic signed [COORD_W-1:0] slot_x_reg    [KEEP_COUNT];
    logic signed [COORD_W-1:0] slot_y_reg    [KEEP_COUNT];
    logic [DIST_W-1:0]         slot_dist_reg [KEEP_COUNT];

    logic [CNT_W-1:0]          eff_used;
    logic [SLOT_W-1:0]         far_eff;
    logic [KEEP_COUNT-1:0]     hit_vec, nearer_vec, win_vec;
    logic                      any_hit, room;
    logic [SLOT_W-1:0]         hit_idx, best_idx, wr_idx;
    logic                      wr_en, load_out, emit_final;

    // A first flag clears the table before the item is looked up.
    assign eff_used = head.first_of_set ? '0 : used_reg;
    assign far_eff  = head.first_of_set ? '0 : farthest_reg;
    assign room     = (eff_used < CNT_W'(KEEP_COUNT));
    assign any_hit  = |hit_vec;

    always_comb
    begin
        for (int i = 0; i < KEEP_COUNT; i++)
        begin
            hit_vec[i]    = (CNT_W'(i) < eff_used) && (slot_key_reg[i] == head.label_key);
            nearer_vec[i] = (head.sq_dist < slot_dist_reg[i]);
        end
        hit_idx = '0;
        for (int i = KEEP_COUNT - 1; i >= 0; i--)
        begin
            if (hit_vec[i])
            begin
                hit_idx = SLOT_W'(i);
            end
        end
    end

    // Slot i is the farthest when it beats every lower slot strictly and
    // every higher slot or equals it, so the lowest index wins ties.
    always_comb
    begin
        for (int i = 0; i < KEEP_COUNT; i++)
        begin
            win_vec[i] = (CNT_W'(i) < used_reg);
            for (int j = 0; j < KEEP_COUNT; j++)
            begin
                if (j != i && CNT_W'(j) < used_reg)
                begin
                    if (j < i)
                    begin
                        win_vec[i] = win_vec[i] && (slot_dist_reg[i] > slot_dist_reg[j]);
                    end
                    else
                    begin
                        win_vec[i] = win_vec[i] && (slot_dist_reg[i] >= slot_dist_reg[j]);
                    end
                end
            end
        end
        best_idx = '0;
        for (int i = KEEP_COUNT - 1; i >= 0; i--)
        begin
            if (win_vec[i])
            begin
                best_idx = SLOT_W'(i);
            end
        end
    end

    assign emit_final = ((CNT_W'(emit_idx_reg) + CNT_W'(1)) == used_reg);

    always_comb
    begin
        state_next    = state_reg;
        used_next     = used_reg;
        farthest_next = farthest_reg;
        last_next     = last_reg;
        emit_idx_next = emit_idx_reg;
        pop           = 1'b0;
        wr_en         = 1'b0;
        wr_idx        = '0;
        load_out      = 1'b0;
        case (state_reg)
            ST_LOOKUP:
            begin
                if (head_valid)
                begin
                    pop           = 1'b1;
                    used_next     = eff_used;
                    farthest_next = far_eff;
                    last_next     = head.last_of_set;
                    emit_idx_next = '0;
                    if (any_hit)
                    begin
                        wr_en  = nearer_vec[hit_idx];
                        wr_idx = hit_idx;
                    end
                    else if (room)
                    begin
                        wr_en     = 1'b1;
                        wr_idx    = eff_used[SLOT_W-1:0];
                        used_next = eff_used + 1'b1;
                    end
                    else
                    begin
                        wr_en  = nearer_vec[far_eff];
                        wr_idx = far_eff;
                    end
                    if (wr_en)
                    begin
                        state_next = ST_FARTHEST;
                    end
                    else if (head.last_of_set && used_next != '0)
                    begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_FARTHEST:
            begin
                farthest_next = best_idx;
                emit_idx_next = '0;
                state_next    = last_reg ? ST_EMIT : ST_LOOKUP;
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    load_out      = 1'b1;
                    emit_idx_next = emit_idx_reg + 1'b1;
                    if (emit_final)
                    begin
                        state_next = ST_LOOKUP;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOOKUP;
            end
        endcase
        out_valid_next = load_out || (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOOKUP;
            used_reg      <= '0;
            farthest_reg  <= '0;
            last_reg      <= 1'b0;
            emit_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            farthest_reg  <= farthest_next;
            last_reg      <= last_next;
            emit_idx_reg  <= emit_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_key_reg[wr_idx]  <= head.label_key;
            slot_x_reg[wr_idx]    <= head.point_x;
            slot_y_reg[wr_idx]    <= head.point_y;
            slot_dist_reg[wr_idx] <= head.sq_dist;
        end
        if (load_out)
        begin
            out_item_reg.kept_key    <= slot_key_reg[emit_idx_reg];
            out_item_reg.kept_x      <= slot_x_reg[emit_idx_reg];
            out_item_reg.kept_y      <= slot_y_reg[emit_idx_reg];
            out_item_reg.final_entry <= emit_final;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

>>> rtl/core/nearest_unique_label_keeper_top.sv
// Top level of the nearest unique label keeper: front end, queue and table engine.
// Depends on nulk_pkg, nulk_front, nulk_queue and nulk_back.
//
// The block keeps up to KEEP_COUNT labeled points nearest to a center, at most
// one per label key. Input transactions (in_valid / in_stall / in_item) carry a
// key, a Q16.8 position and first/last flags. Output transactions (out_valid /
// out_stall / out_item) carry one held entry each, in slot order, with
// final_entry set on the last one; only items with the last flag produce them.
// The configuration channel (cfg_valid / cfg_ready, cfg_index, cfg_data) writes
// center_x at index 0 and center_y at index 1 and ignores other indexes;
// cfg_ready is always high, and the user must see that writes are made only while
// the block is idle; the block itself does not enforce this. Two front-end stages
// square the offsets and the queue adds one more register stage ahead of the table
// engine. The front end takes one item per cycle while in_stall is low; the engine
// handles an item that leaves the table unchanged in the lookup state alone, and
// one that writes a slot in the lookup state and then the farthest-slot recompute,
// and emits the held entries one at a time. A two-entry queue lets the front end
// keep accepting while the engine works or emits. Reset empties the table,
// pipeline and queue and zeroes the center. While out_stall is high the output
// register holds its entry; once queue and pipeline fill, in_stall rises.
module nearest_unique_label_keeper_top #(
    parameter int KEEP_COUNT = nulk_pkg::KEEP_COUNT_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [nulk_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic signed [nulk_pkg::COORD_W-1:0] cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  nulk_pkg::in_item_t                  in_item,
    output logic                                out_valid,
    input  logic                                out_stall,
    output nulk_pkg::out_item_t                 out_item
);
    import nulk_pkg::*;

    logic push, queue_full, queue_empty, pop;
    job_t push_job, head;

    // Configuration writes go straight into the center registers, so the port never pushes back.
    assign cfg_ready = 1'b1;

    nulk_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_item    (in_item),
        .push       (push),
        .queue_full (queue_full),
        .push_job   (push_job)
    );

    nulk_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .full     (queue_full),
        .pop      (pop),
        .empty    (queue_empty),
        .head     (head)
    );

    nulk_back #(
        .KEEP_COUNT (KEEP_COUNT)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (!queue_empty),
        .head       (head),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_item   (out_item)
    );

endmodule

>>> rtl/core/nulk_checker.sv
// Port-level checker for the nearest unique label keeper, bound to the top level.
// Depends on nulk_pkg and nearest_unique_label_keeper_top.
module nulk_checker #(
    parameter int KEEP_COUNT = nulk_pkg::KEEP_COUNT_DEF
) (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_stall,
    input nulk_pkg::in_item_t  in_item,
    input logic                out_valid,
    input logic                out_stall,
    input nulk_pkg::out_item_t out_item
);
    import nulk_pkg::*;

    localparam int CNT_W = $clog2(KEEP_COUNT + 1);

    logic [3:0]       pending_reg, pending_next;
    logic [CNT_W-1:0] run_reg, run_next;
    logic             in_acc, out_acc;

    assign in_acc  = in_valid && !in_stall;
    assign out_acc = out_valid && !out_stall;

    // Items with the last flag whose final entry has not yet left.
    always_comb
    begin
        pending_next = pending_reg;
        if (in_acc && in_item.last_of_set && !(out_acc && out_item.final_entry))
        begin
            pending_next = pending_reg + 1'b1;
        end
        else if (!(in_acc && in_item.last_of_set) && out_acc && out_item.final_entry)
        begin
            pending_next = pending_reg - 1'b1;
        end
        run_next = run_reg;
        if (out_acc)
        begin
            run_next = out_item.final_entry ? '0 : run_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
            run_reg     <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
            run_reg     <= run_next;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_item))
        else $error("stalled output transaction changed");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(in_stall) |-> $past(in_valid && !in_stall))
        else $error("input stall rose without a preceding input transaction");

    a_out_needs_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pending_reg != '0)
        else $error("output shown with no outstanding last-of-set item");

    a_run_length: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall |-> run_reg < CNT_W'(KEEP_COUNT))
        else $error("emitted run longer than the table");

endmodule

bind nearest_unique_label_keeper_top nulk_checker #(
    .KEEP_COUNT (KEEP_COUNT)
) u_nulk_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
);
